### rtl/assert_macros.svh
// Assertion macros used by the list engine datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while rst is low.
`define BSLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("list engine check failed");

// Checked at every rising edge of clk, reset included.
`define BSLE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("list engine check failed");

`endif

### rtl/bsle_pkg.sv
// Shared constants, codes and interface types of the list engine.
`timescale 1ns / 1ps
`default_nettype none

package bsle_pkg;

  // Storage geometry.
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command codes carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_TAIL  = 3'd1,
    CMD_REMOVE     = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_REVERSE    = 3'd4,
    CMD_READ_OUT   = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  // Status codes carried by a result item.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [1:0] {
    DP_NONE = 2'd0,
    DP_EXEC = 2'd1,
    DP_STEP = 2'd2
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // the result register can take a new item this cycle
    logic multi;      // the list holds more than one entry
    logic read_last;  // the next read step gives the final entry
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/bsle_ctrl.sv
// Controller state machine of the list engine.
`timescale 1ns / 1ps
`default_nettype none

module bsle_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [bsle_pkg::CMD_W-1:0] cmd,
  input  wire bsle_pkg::dp_stat_t        dp_stat,
  output bsle_pkg::dp_cmd_t              dp_cmd,
  output logic                           in_stall
);

  bsle_pkg::state_t state;
  bsle_pkg::state_t state_next;
  logic             is_read;

  assign is_read = (cmd == bsle_pkg::CMD_READ_OUT);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a read out of several entries stays in S_READ until the last one.
  always_comb begin
    state_next = state;
    case (state)
      bsle_pkg::S_IDLE: begin
        if (in_valid && dp_stat.out_free && is_read && dp_stat.multi) begin
          state_next = bsle_pkg::S_READ;
        end
      end
      bsle_pkg::S_READ: begin
        if (dp_stat.out_free && dp_stat.read_last) begin
          state_next = bsle_pkg::S_IDLE;
        end
      end
      default: state_next = bsle_pkg::S_IDLE;
    endcase
  end

  // Outputs: accept an item only when idle and the result register frees up.
  always_comb begin
    dp_cmd.op = bsle_pkg::DP_NONE;
    in_stall  = 1'b1;
    case (state)
      bsle_pkg::S_IDLE: begin
        in_stall = !dp_stat.out_free;
        if (in_valid && dp_stat.out_free) begin
          dp_cmd.op = bsle_pkg::DP_EXEC;
        end
      end
      bsle_pkg::S_READ: begin
        if (dp_stat.out_free) begin
          dp_cmd.op = bsle_pkg::DP_STEP;
        end
      end
      default: begin
        dp_cmd.op = bsle_pkg::DP_NONE;
        in_stall  = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/bsle_datapath.sv
// Entry registers, count, read-out counter and result register of the list engine.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bsle_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bsle_pkg::dp_cmd_t                 dp_cmd,
  output bsle_pkg::dp_stat_t                     dp_stat,
  input  wire logic [bsle_pkg::CMD_W-1:0]        cmd,
  input  wire logic [bsle_pkg::POS_W-1:0]        position,
  input  wire logic signed [bsle_pkg::DATA_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bsle_pkg::STAT_W-1:0]            status,
  output logic signed [bsle_pkg::DATA_W-1:0]     element,
  output logic                                   element_valid,
  output logic                                   last
);

  localparam int CAPACITY = bsle_pkg::CAPACITY;
  localparam int CNT_W    = bsle_pkg::CNT_W;
  localparam int IDX_W    = bsle_pkg::IDX_W;
  localparam int DATA_W   = bsle_pkg::DATA_W;
  localparam int CMP_W    = bsle_pkg::CMP_W;

  logic [DATA_W-1:0] entries      [CAPACITY];
  logic [DATA_W-1:0] entries_next [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  read_left;
  logic [CNT_W-1:0]  read_left_next;

  bsle_pkg::status_t status_next;
  logic [DATA_W-1:0] element_next;
  logic              element_valid_next;
  logic              last_next;

  bsle_pkg::cmd_t    cmd_c;
  logic              list_full;
  logic              list_empty;
  logic [CNT_W-1:0]  count_m1;
  logic [CMP_W-1:0]  pos_cmp;
  logic [CMP_W-1:0]  count_cmp;
  logic              out_free;
  logic              is_grow;
  logic              grow_ok;

  assign cmd_c      = bsle_pkg::cmd_t'(cmd);
  assign list_full  = (count == CNT_W'(CAPACITY));
  assign list_empty = (count == '0);
  assign count_m1   = count - CNT_W'(1);
  assign pos_cmp    = CMP_W'(position);
  assign count_cmp  = CMP_W'(count);
  assign out_free   = !out_valid || !out_stall;

  assign dp_stat.out_free  = out_free;
  assign dp_stat.multi     = (count > CNT_W'(1));
  assign dp_stat.read_last = (read_left == CNT_W'(1));

  // Command decode and the edit of the entry registers.
  always_comb begin
    logic             ins_en;
    logic             rem_en;
    logic             rot_en;
    logic             rev_en;
    logic [CNT_W-1:0] ins_pos;
    logic [CNT_W-1:0] rev_src;

    ins_en             = 1'b0;
    rem_en             = 1'b0;
    rot_en             = 1'b0;
    rev_en             = 1'b0;
    ins_pos            = '0;
    rev_src            = '0;
    entries_next       = entries;
    count_next         = count;
    read_left_next     = read_left;
    status_next        = bsle_pkg::ST_OK;
    element_next       = '0;
    element_valid_next = 1'b0;
    last_next          = 1'b1;

    case (dp_cmd.op)
      bsle_pkg::DP_EXEC: begin
        case (cmd_c)
          bsle_pkg::CMD_PUSH_FRONT: begin
            if (list_full) begin
              status_next = bsle_pkg::ST_FULL;
            end else begin
              ins_en  = 1'b1;
              ins_pos = '0;
            end
          end
          bsle_pkg::CMD_PUSH_TAIL: begin
            if (list_full) begin
              status_next = bsle_pkg::ST_FULL;
            end else begin
              ins_en  = 1'b1;
              ins_pos = count;
            end
          end
          bsle_pkg::CMD_REMOVE: begin
            if (list_empty) begin
              status_next = bsle_pkg::ST_EMPTY;
            end else begin
              rem_en = 1'b1;
            end
          end
          bsle_pkg::CMD_INSERT: begin
            if (pos_cmp > count_cmp) begin
              status_next = bsle_pkg::ST_BADPOS;
            end else if (list_full) begin
              status_next = bsle_pkg::ST_FULL;
            end else begin
              ins_en  = 1'b1;
              ins_pos = CNT_W'(pos_cmp);
            end
          end
          bsle_pkg::CMD_REVERSE: begin
            rev_en = 1'b1;
          end
          bsle_pkg::CMD_READ_OUT: begin
            // An empty list gives one plain status item.
            if (!list_empty) begin
              element_next       = entries[0];
              element_valid_next = 1'b1;
              last_next          = (count == CNT_W'(1));
              rot_en             = 1'b1;
              read_left_next     = count_m1;
            end
          end
          bsle_pkg::CMD_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end
      bsle_pkg::DP_STEP: begin
        element_next       = entries[0];
        element_valid_next = 1'b1;
        last_next          = (read_left == CNT_W'(1));
        rot_en             = 1'b1;
        read_left_next     = read_left - CNT_W'(1);
      end
      default: begin
      end
    endcase

    // Insert: later entries move back by one, the new value lands at ins_pos.
    if (ins_en) begin
      for (int i = 1; i < CAPACITY; i++) begin
        if (CNT_W'(i) > ins_pos) begin
          entries_next[i] = entries[i-1];
        end
      end
      entries_next[ins_pos[IDX_W-1:0]] = value;
      count_next = count + CNT_W'(1);
    end

    // Remove front: everything moves forward by one.
    if (rem_en) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        entries_next[i] = entries[i+1];
      end
      count_next = count_m1;
    end

    // Read out rotates the held entries so the front is always at index zero;
    // after count steps the order is back where it began.
    if (rot_en) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        entries_next[i] = entries[i+1];
      end
      entries_next[count_m1[IDX_W-1:0]] = entries[0];
    end

    // Reverse the held entries in one pass.
    if (rev_en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (CNT_W'(i) < count) begin
          rev_src         = count_m1 - CNT_W'(i);
          entries_next[i] = entries[rev_src[IDX_W-1:0]];
        end
      end
    end
  end

  // Entry registers hold payload only and take no reset.
  always_ff @(posedge clk) begin
    entries <= entries_next;
  end

  // Count and read-out counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      read_left <= '0;
    end else begin
      count     <= count_next;
      read_left <= read_left_next;
    end
  end

  // Result register: loads a new item whenever the controller asks for one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.op != bsle_pkg::DP_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op != bsle_pkg::DP_NONE) begin
      status        <= status_next;
      element       <= element_next;
      element_valid <= element_valid_next;
      last          <= last_next;
    end
  end

  // The count never passes the capacity.
  `BSLE_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY))

  // A read step never runs when nothing is left to give.
  `BSLE_ASSERT(a_step_has_work, (dp_cmd.op == bsle_pkg::DP_STEP) |-> (read_left != '0))

  // A successful grow command adds exactly one entry.
  assign is_grow = (cmd_c == bsle_pkg::CMD_PUSH_FRONT) || (cmd_c == bsle_pkg::CMD_PUSH_TAIL) ||
                   (cmd_c == bsle_pkg::CMD_INSERT);
  assign grow_ok = (dp_cmd.op == bsle_pkg::DP_EXEC) && is_grow &&
                   (status_next == bsle_pkg::ST_OK);
  `BSLE_ASSERT(a_grow_counts, grow_ok |=> (count == $past(count) + CNT_W'(1)))

  // A read step leaves the count untouched.
  `BSLE_ASSERT(a_step_keeps_count, (dp_cmd.op == bsle_pkg::DP_STEP) |=> $stable(count))

endmodule

`default_nettype wire

### rtl/bounded_sequence_list_engine_top.sv
// Top level of the list engine: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps an ordered list of up to 16 signed 32-bit entries in a
// row of registers and answers each command item with result items. Push,
// insert, remove, reverse and clear act on the registers directly, so such
// items go through at one per cycle while results are taken; the single
// result register holds them back while results wait. A read out of n
// entries gives n result items at one per cycle while results are taken
// (one item when the list is empty) and, after taking the read-out item,
// stalls the input while the list rotates the remaining entries past its
// front register. No clearing pass is needed after reset.
module bounded_sequence_list_engine_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [bsle_pkg::CMD_W-1:0]         cmd,
  input  wire logic [bsle_pkg::POS_W-1:0]         position,
  input  wire logic signed [bsle_pkg::DATA_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [bsle_pkg::STAT_W-1:0]             status,
  output logic signed [bsle_pkg::DATA_W-1:0]      element,
  output logic                                    element_valid,
  output logic                                    last
);

  bsle_pkg::dp_cmd_t  dp_cmd;
  bsle_pkg::dp_stat_t dp_stat;

  // Sequencing of items and read-out steps.
  bsle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd),
    .in_stall (in_stall)
  );

  // Entry storage and result register.
  bsle_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .dp_stat       (dp_stat),
    .cmd           (cmd),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .element       (element),
    .element_valid (element_valid),
    .last          (last)
  );

endmodule

`default_nettype wire
